### src/adaptive_step_detector_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the adaptive step detector
// Define NO_ASSERTIONS to compile them out.
// ---------------------------------------------------------------------------
`ifndef ADAPTIVE_STEP_DETECTOR_MACROS_SVH
`define ADAPTIVE_STEP_DETECTOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("step detector check failed (same cycle)");

// next-cycle implication
`define ASD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("step detector check failed (next cycle)");

`else

`define ASD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### src/asd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// asd_pkg
// Field widths, register codes and sensitivity tables of the step detector.
// ---------------------------------------------------------------------------
package asd_pkg;

    localparam int COUNT_W    = 24;
    localparam int CAL_W      = 20;
    localparam int GOAL_W     = 24;
    localparam int BASE_W     = 24;
    localparam int MODE_W     = 2;
    localparam int THR_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int OUT_TDATA_W = ((2 * COUNT_W + 2 * CAL_W + 7) / 8) * 8;

    localparam int CAL_DIV     = 22;
    localparam int CAL_DIV_LOG = $clog2(CAL_DIV);
    localparam int OVERSHOOT   = 200;
    localparam int ADAPT_STEP  = 2;
    localparam int BAND_HALF   = 10;

    typedef enum logic [MODE_W-1:0] {
        MODE_DEFAULT   = 2'd0,
        MODE_REGULAR   = 2'd1,
        MODE_NOT_SENS  = 2'd2,
        MODE_VERY_SENS = 2'd3
    } sens_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENS_MODE = 2'd0,
        REG_STEP_GOAL = 2'd1,
        REG_LIFE_BASE = 2'd2
    } cfg_reg_t;

    function automatic logic [THR_W-1:0] x_threshold(input logic [MODE_W-1:0] mode);
        logic [THR_W-1:0] thr;
        case (mode)
            MODE_NOT_SENS:  thr = THR_W'(45);
            MODE_VERY_SENS: thr = THR_W'(25);
            default:        thr = THR_W'(35);
        endcase
        return thr;
    endfunction

    // start value of the Y/Z thresholds; the adapt band is this +/- BAND_HALF
    function automatic logic [THR_W-1:0] mode_value(input logic [MODE_W-1:0] mode);
        logic [THR_W-1:0] thr;
        case (mode)
            MODE_NOT_SENS:  thr = THR_W'(235);
            MODE_VERY_SENS: thr = THR_W'(110);
            default:        thr = THR_W'(185);
        endcase
        return thr;
    endfunction

endpackage

### src/adaptive_step_detector.sv
`timescale 1ns / 1ps
`include "adaptive_step_detector_macros.svh"
// ---------------------------------------------------------------------------
// adaptive_step_detector
// Step detection on three-axis acceleration samples with adaptive Y/Z
// thresholds, session and lifetime step counters and calorie estimates.
//
//   channel   | dir | payload
//   ----------+-----+-----------------------------------------------------
//   cfg_*     | in  | register index, write data (mode, goal, lifetime base)
//   s_axis_*  | in  | accel_x/y/z samples, vibrating flag
//   m_axis_*  | out | step/goal flags, session and lifetime counts, calories
//
// One sample per cycle while m_axis does not stall; a result passes the input,
// detect, lifetime and output registers. The rate is set by the state update
// in the detect stage (previous sample, thresholds, session count).
// Reset is synchronous: config returns to mode 1, goal 0, lifetime base 1.
// A stall on m_axis backs up stage by stage; empty stages keep filling.
// Config port is always ready.
// ---------------------------------------------------------------------------
module adaptive_step_detector
    import asd_pkg::*;
#(
    parameter int COUNT_BITS  = 24,
    parameter int SAMPLE_BITS = 13,
    localparam int IN_TDATA_W = ((3 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // accel_x, accel_y, accel_z, zero pad
    input  logic [0:0]             s_axis_tuser,  // vibrating

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // step_count, session_calories,
                                                  // lifetime_steps, lifetime_calories
    output logic [1:0]             m_axis_tuser   // step_detected, goal_reached
);

    localparam int DW        = SAMPLE_BITS + 2;
    localparam int CMP_W     = (COUNT_BITS > GOAL_W) ? COUNT_BITS : GOAL_W;
    localparam int SUM_W     = CMP_W + 1;
    localparam int PROD_W    = 2 * COUNT_BITS + 1;
    localparam int CAL_SHIFT = COUNT_BITS + CAL_DIV_LOG;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    // rounded-up reciprocal of the calorie divisor, exact for every count
    localparam logic [COUNT_BITS:0] CAL_MULT =
        (COUNT_BITS + 1)'(((64'd1 << CAL_SHIFT) / CAL_DIV) + 64'd1);

    function automatic logic signed [DW-1:0] mag_change(
        input logic signed [SAMPLE_BITS-1:0] cur,
        input logic signed [SAMPLE_BITS-1:0] prv
    );
        logic signed [DW-1:0] ac;
        logic signed [DW-1:0] ap;
        logic signed [DW-1:0] d;
        ac = DW'(cur);
        ap = DW'(prv);
        if (ac < 0) ac = -ac;
        if (ap < 0) ap = -ap;
        d = ac - ap;
        if (d < 0) d = -d;
        return d;
    endfunction

    function automatic logic [THR_W-1:0] adapt_thr(
        input logic signed [DW-1:0] change,
        input logic [THR_W-1:0]     thr,
        input logic [MODE_W-1:0]    mode
    );
        logic signed [DW-1:0] thr_s;
        logic signed [DW-1:0] over;
        logic [THR_W-1:0]     lo;
        logic [THR_W-1:0]     hi;
        logic [THR_W-1:0]     t;
        thr_s = $signed(DW'(thr));
        over  = change - thr_s;
        lo    = mode_value(mode) - THR_W'(BAND_HALF);
        hi    = mode_value(mode) + THR_W'(BAND_HALF);
        t     = thr;
        if ((change >= thr_s) && (over > $signed(DW'(OVERSHOOT)))) begin
            if (thr > hi) begin
                t = hi;
            end else if (thr < lo) begin
                t = lo;
            end
            if (t < hi) t = t + THR_W'(ADAPT_STEP);
        end
        return t;
    endfunction

    function automatic logic [CAL_W-1:0] calories(input logic [COUNT_BITS-1:0] n);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(n) * PROD_W'(CAL_MULT);
        return CAL_W'(prod[PROD_W-1:CAL_SHIFT]);
    endfunction

    // config registers
    logic [MODE_W-1:0] mode_reg;
    logic [GOAL_W-1:0] goal_reg;
    logic [BASE_W-1:0] base_reg;

    // input stage
    logic                          a_valid_reg;
    logic signed [SAMPLE_BITS-1:0] a_x_reg, a_y_reg, a_z_reg;
    logic                          a_vib_reg;

    // detector state
    logic                          armed_reg;
    logic signed [SAMPLE_BITS-1:0] prev_x_reg, prev_y_reg, prev_z_reg;
    logic [THR_W-1:0]              y_thr_reg, z_thr_reg;
    logic [COUNT_BITS-1:0]         count_reg;

    // detect stage result
    logic                  b_valid_reg;
    logic                  b_step_reg;
    logic                  b_goal_reg;
    logic [COUNT_BITS-1:0] b_count_reg;

    // lifetime stage
    logic                  c_valid_reg;
    logic                  c_step_reg;
    logic                  c_goal_reg;
    logic [COUNT_W-1:0]    c_count_reg;
    logic [CAL_W-1:0]      c_scal_reg;
    logic [COUNT_BITS-1:0] c_life_reg;

    // output register
    logic               m_valid_reg;
    logic               d_step_reg;
    logic               d_goal_reg;
    logic [COUNT_W-1:0] d_count_reg;
    logic [CAL_W-1:0]   d_scal_reg;
    logic [COUNT_W-1:0] d_life_reg;
    logic [CAL_W-1:0]   d_lcal_reg;

    logic ld_a, ld_b, ld_c, ld_d;
    logic cfg_wr;

    logic signed [DW-1:0]  dx, dy, dz;
    logic                  x_hit, y_hit, z_hit;
    logic                  step;
    logic                  count_inc;
    logic [COUNT_BITS-1:0] count_next;
    logic                  goal_hit;
    logic [THR_W-1:0]      y_thr_next, z_thr_next;
    logic [SUM_W-1:0]      life_sum;
    logic [COUNT_BITS-1:0] life;

    // ---------------- flow control ----------------
    assign ld_d = !m_valid_reg || m_axis_tready;
    assign ld_c = !c_valid_reg || ld_d;
    assign ld_b = !b_valid_reg || ld_c;
    assign ld_a = !a_valid_reg || ld_b;

    assign s_axis_tready = ld_a;
    assign cfg_ready     = 1'b1;
    assign cfg_wr        = cfg_valid && cfg_ready;

    // ---------------- config ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_REGULAR;
            goal_reg <= '0;
            base_reg <= BASE_W'(1);
        end else if (cfg_wr) begin
            case (cfg_index)
                REG_SENS_MODE: mode_reg <= cfg_data[MODE_W-1:0];
                REG_STEP_GOAL: goal_reg <= cfg_data[GOAL_W-1:0];
                REG_LIFE_BASE: base_reg <= cfg_data[BASE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (ld_a) begin
            a_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_a && s_axis_tvalid) begin
            a_x_reg   <= s_axis_tdata[SAMPLE_BITS-1:0];
            a_y_reg   <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            a_z_reg   <= s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
            a_vib_reg <= s_axis_tuser[0];
        end
    end

    // ---------------- detect stage ----------------
    always_comb begin
        dx         = mag_change(a_x_reg, prev_x_reg);
        dy         = mag_change(a_y_reg, prev_y_reg);
        dz         = mag_change(a_z_reg, prev_z_reg);
        x_hit      = dx >= $signed(DW'(x_threshold(mode_reg)));
        y_hit      = dy >= $signed(DW'(y_thr_reg));
        z_hit      = dz >= $signed(DW'(z_thr_reg));
        y_thr_next = adapt_thr(dy, y_thr_reg, mode_reg);
        z_thr_next = adapt_thr(dz, z_thr_reg, mode_reg);
        step       = armed_reg && x_hit && (y_hit || z_hit) && !a_vib_reg;
        count_inc  = step && (count_reg != COUNT_MAX);
        count_next = count_reg + COUNT_BITS'(1);
        goal_hit   = count_inc && (goal_reg != '0) &&
                     (CMP_W'(count_next) == CMP_W'(goal_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg  <= 1'b0;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            prev_z_reg <= '0;
            y_thr_reg  <= mode_value(MODE_REGULAR);
            z_thr_reg  <= mode_value(MODE_REGULAR);
            count_reg  <= '0;
        end else if (cfg_wr && (cfg_index == REG_SENS_MODE)) begin
            // mode change reloads both adaptive thresholds
            y_thr_reg <= mode_value(cfg_data[MODE_W-1:0]);
            z_thr_reg <= mode_value(cfg_data[MODE_W-1:0]);
        end else if (ld_b && a_valid_reg) begin
            if (armed_reg) begin
                prev_x_reg <= a_x_reg;
                prev_y_reg <= a_y_reg;
                prev_z_reg <= a_z_reg;
                y_thr_reg  <= y_thr_next;
                z_thr_reg  <= z_thr_next;
                if (count_inc) count_reg <= count_next;
            end else begin
                // first sample only arms
                armed_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (ld_b) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_b && a_valid_reg) begin
            b_step_reg  <= step;
            b_goal_reg  <= goal_hit;
            b_count_reg <= count_inc ? count_next : count_reg;
        end
    end

    // ---------------- lifetime stage ----------------
    always_comb begin
        life_sum = SUM_W'(base_reg) + SUM_W'(b_count_reg);
        life     = (life_sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : life_sum[COUNT_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (ld_c) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_c && b_valid_reg) begin
            c_step_reg  <= b_step_reg;
            c_goal_reg  <= b_goal_reg;
            c_count_reg <= COUNT_W'(b_count_reg);
            c_scal_reg  <= calories(b_count_reg);
            c_life_reg  <= life;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ld_d) begin
            m_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_d && c_valid_reg) begin
            d_step_reg  <= c_step_reg;
            d_goal_reg  <= c_goal_reg;
            d_count_reg <= c_count_reg;
            d_scal_reg  <= c_scal_reg;
            d_life_reg  <= COUNT_W'(c_life_reg);
            d_lcal_reg  <= calories(c_life_reg);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({d_lcal_reg, d_life_reg, d_scal_reg, d_count_reg});
    assign m_axis_tuser  = {d_goal_reg, d_step_reg};

    // ---------------- assertions ----------------
    `ASD_ASSERT_IMP(a_full_stall_blocks, aclk, aresetn, a_valid_reg && b_valid_reg && c_valid_reg && m_valid_reg && !m_axis_tready, !s_axis_tready)
    `ASD_ASSERT_NEXT(a_count_moves_by_one, aclk, aresetn, 1'b1, (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + COUNT_BITS'(1)))
    `ASD_ASSERT_NEXT(a_y_thr_never_drops, aclk, aresetn, !(cfg_wr && (cfg_index == REG_SENS_MODE)), y_thr_reg >= $past(y_thr_reg))
    `ASD_ASSERT_NEXT(a_z_thr_never_drops, aclk, aresetn, !(cfg_wr && (cfg_index == REG_SENS_MODE)), z_thr_reg >= $past(z_thr_reg))
    `ASD_ASSERT_IMP(a_goal_matches_count, aclk, aresetn, m_valid_reg && d_goal_reg, d_step_reg && (d_count_reg == goal_reg))

endmodule
